### hw/rtl/isort_pkg.sv
// shared types and constants for the insertion sorter
package isort_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic  insert;  // place value into the sorted row
        logic  drain;   // shift the row one place toward the head
        t_data value;   // value being inserted
    } t_cell_ctl;

endpackage

### hw/rtl/isort_cell.sv
// one cell of the sorted row: holds a value and a valid bit
module isort_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  logic                 i_left_take,
    input  logic                 i_left_valid,
    input  isort_pkg::t_data     i_left_value,
    input  logic                 i_right_valid,
    input  isort_pkg::t_data     i_right_value,
    output logic                 o_take,
    output logic                 o_valid,
    output isort_pkg::t_data     o_value
);

    logic             r_valid;
    isort_pkg::t_data r_value;
    logic             n_valid;
    isort_pkg::t_data n_value;

    // new value belongs at this place or before it
    assign o_take  = !r_valid || (r_value > i_ctl.value);
    assign o_valid = r_valid;
    assign o_value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.insert) begin
            if (o_take && !i_left_take) begin
                n_valid = 1'b1;
                n_value = i_ctl.value;
            end else if (o_take) begin
                n_valid = i_left_valid;
                n_value = i_left_value;
            end
        end else if (i_ctl.drain) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### hw/rtl/insertion_sorter_core.sv
// insertion sorter top level: chain of sorting cells plus batch control
// items that fit are registered into the row; the first result comes the cycle after the batch end
// throughput: 1 item per cycle while collecting, 1 result per receiver-ready cycle while draining
// a batch is collected item by item, then drained result by result; input is held off while draining
// draining is paced by the receiver; the head cell doubles as the output register
// reset (synchronous, active low) empties every cell, clears the drop flag and returns to collecting
module insertion_sorter_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [31:0]     i_sample_value,
    input  logic                   i_batch_end,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [31:0]     o_sorted_value,
    output logic                   o_final_flag,
    output logic                   o_overflowed
);

    localparam int N = isort_pkg::CAPACITY;

    isort_pkg::t_state    r_state;
    isort_pkg::t_state    n_state;
    logic                 r_drop;
    logic                 n_drop;
    isort_pkg::t_cell_ctl ctl;

    // per-cell taps of the chain
    logic [N-1:0]             take;
    logic [N-1:0]             valid;
    isort_pkg::t_data [N-1:0] value;

    logic in_fire;
    logic out_fire;
    logic full;

    // row is full once the tail cell holds a value
    assign full     = valid[N-1];
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isort_pkg::ST_COLLECT: begin
                if (in_fire && i_batch_end) begin
                    n_state = isort_pkg::ST_DRAIN;
                end
            end
            isort_pkg::ST_DRAIN: begin
                if (out_fire && o_final_flag) begin
                    n_state = isort_pkg::ST_COLLECT;
                end
            end
            default: n_state = isort_pkg::ST_COLLECT;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        ctl.insert   = 1'b0;
        ctl.drain    = 1'b0;
        ctl.value    = i_sample_value;
        unique case (r_state)
            isort_pkg::ST_COLLECT: begin
                o_in_ready = 1'b1;
                // a value arriving on a full row is dropped
                ctl.insert = in_fire && !full;
            end
            isort_pkg::ST_DRAIN: begin
                o_out_valid = valid[0];
                ctl.drain   = out_fire;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // drop flag: set by any lost value, cleared once the batch has left
    always_comb begin
        n_drop = r_drop;
        if (in_fire && full) begin
            n_drop = 1'b1;
        end else if (out_fire && o_final_flag) begin
            n_drop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isort_pkg::ST_COLLECT;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drop  <= n_drop;
        end
    end

    // the row of cells; the head cell is read directly as the output register
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic             left_take;
        logic             left_valid;
        isort_pkg::t_data left_value;
        logic             right_valid;
        isort_pkg::t_data right_value;

        if (g == 0) begin : g_head
            assign left_take  = 1'b0;
            assign left_valid = 1'b0;
            assign left_value = '0;
        end else begin : g_link_left
            assign left_take  = take[g-1];
            assign left_valid = valid[g-1];
            assign left_value = value[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_value = '0;
        end else begin : g_link_right
            assign right_valid = valid[g+1];
            assign right_value = value[g+1];
        end

        isort_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_left_take   (left_take),
            .i_left_valid  (left_valid),
            .i_left_value  (left_value),
            .i_right_valid (right_valid),
            .i_right_value (right_value),
            .o_take        (take[g]),
            .o_valid       (valid[g]),
            .o_value       (value[g])
        );
    end

    assign o_sorted_value = value[0];
    // last result when nothing stands behind the head cell
    assign o_final_flag   = !valid[1];
    assign o_overflowed   = r_drop;

    // stored values always form an unbroken run from the head
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid >> 1) & ~valid) == '0)
        else $error("gap in the sorted row");

    // input and output never open together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("collect and drain overlap");

    // the final result leaves the row empty and the drop flag clear
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_final_flag) |=> (valid == '0 && !r_drop))
        else $error("row not empty after batch");

    // a dropped value leaves the row full and marks the batch
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && full) |=> (full && r_drop))
        else $error("drop not recorded");

endmodule

### tb/sv/insertion_sorter_core_tb.sv
// self-checking testbench for the insertion sorter core
module insertion_sorter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT  = 200000;  // cycles before the run is declared hung
    localparam int HOLD_SPAN  = 400;     // long receiver hold-off, in cycles
    localparam int TAIL_WAIT  = 8;       // quiet cycles after the last result

    localparam isort_pkg::t_data MOST_NEG = 32'sh8000_0000;
    localparam isort_pkg::t_data MOST_POS = 32'sh7fff_ffff;

    // one item toward the sorter and one sorted result out of it
    typedef struct {
        isort_pkg::t_data value;
        logic             last;
    } t_sample;

    typedef struct {
        isort_pkg::t_data value;
        logic             final_flag;
        logic             overflowed;
    } t_sorted;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    isort_pkg::t_data i_sample_value;
    logic             i_batch_end;
    logic             o_out_valid;
    logic             i_out_ready;
    isort_pkg::t_data o_sorted_value;
    logic             o_final_flag;
    logic             o_overflowed;

    insertion_sorter_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_batch_end    (i_batch_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_final_flag   (o_final_flag),
        .o_overflowed   (o_overflowed)
    );

    // items waiting to be offered, results waiting to be seen
    t_sample sample_queue[$];
    t_sorted expected_sorted[$];

    // predicted contents of the sorting row
    isort_pkg::t_data sort_row[isort_pkg::CAPACITY];
    int               row_fill;
    logic             row_dropped;

    int mismatches;
    int run_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    // receiver hold-off: the stimulus asks, the stall process serves
    int hold_asks;
    int hold_served;
    int hold_left;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", run_cycles, what);
        mismatches++;
    endtask

    // insert one accepted item; on batch end, queue the whole sorted row
    function automatic void absorb_sample(input t_sample s);
        int      pos;
        int      k;
        t_sorted r;
        if (row_fill >= isort_pkg::CAPACITY) begin
            // full row: value is lost and the batch is marked
            row_dropped = 1'b1;
        end else begin
            pos = 0;
            // equal values stay in arrival order, so step past them
            while (pos < row_fill && sort_row[pos] <= s.value)
                pos++;
            for (k = row_fill; k > pos; k--)
                sort_row[k] = sort_row[k-1];
            sort_row[pos] = s.value;
            row_fill++;
        end
        if (s.last) begin
            for (k = 0; k < row_fill; k++) begin
                r.value      = sort_row[k];
                r.final_flag = (k == row_fill - 1);
                r.overflowed = row_dropped;
                expected_sorted.push_back(r);
            end
            row_fill    = 0;
            row_dropped = 1'b0;
        end
    endfunction

    // mix of extremes, a narrow band with many repeats, and full-range values
    function automatic isort_pkg::t_data pick_value();
        case ($urandom_range(9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return isort_pkg::t_data'(int'($urandom_range(8)) - 4);
            default: return isort_pkg::t_data'($urandom);
        endcase
    endfunction

    function automatic void push_sample(input isort_pkg::t_data value, input logic last);
        t_sample s;
        s.value = value;
        s.last  = last;
        sample_queue.push_back(s);
    endfunction

    function automatic void push_batch(input int len);
        int i;
        for (i = 0; i < len; i++)
            push_sample(pick_value(), i == len - 1);
    endfunction

    // short random batches until n items are queued
    function automatic void push_short_batches(input int n);
        int len;
        while (n > 0) begin
            len = $urandom_range(8, 1);
            if (len > n)
                len = n;
            push_batch(len);
            n -= len;
        end
    endfunction

    // wait until every item is taken and every result has come back
    task automatic wait_drained();
        while (sample_queue.size() != 0 || i_in_valid || expected_sorted.size() != 0)
            @(posedge i_clk);
    endtask

    // sender: holds the offered item until taken, idles at random otherwise
    always @(posedge i_clk) begin : drive_samples
        logic stuck;
        if (!i_rst_n) begin
            i_in_valid     <= 1'b0;
            i_sample_value <= '0;
            i_batch_end    <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                absorb_sample(sample_queue.pop_front());
            stuck = i_in_valid && !o_in_ready;
            if (!stuck) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid     <= 1'b1;
                    i_sample_value <= sample_queue[0].value;
                    i_batch_end    <= sample_queue[0].last;
                end else begin
                    i_in_valid     <= 1'b0;
                    i_sample_value <= isort_pkg::t_data'($urandom);
                    i_batch_end    <= 1'($urandom_range(1));
                end
            end
        end
    end

    // long hold-off of the receiver, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_served != hold_asks) begin
            hold_left   <= HOLD_SPAN;
            hold_served <= hold_served + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver readiness
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_sorted want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", o_sorted_value));
            end else begin
                want = expected_sorted.pop_front();
                if (o_sorted_value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              o_sorted_value, want.value));
                if (o_final_flag !== want.final_flag)
                    report_mismatch($sformatf("final flag got %b want %b",
                                              o_final_flag, want.final_flag));
                if (o_overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflow flag got %b want %b",
                                              o_overflowed, want.overflowed));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", run_cycles);
            $display("insertion_sorter_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        mismatches    = 0;
        run_cycles    = 0;
        row_fill      = 0;
        row_dropped   = 1'b0;
        hold_asks     = 0;
        hold_served   = 0;
        send_idle_pct = 30;
        recv_idle_pct = 74;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed batches, with the receiver held off so the sorter backs up
        @(negedge i_clk);
        push_sample(MOST_POS, 1'b0);
        push_sample(MOST_NEG, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(1, 1'b1);
        push_sample(MOST_NEG, 1'b1);            // batch of one
        push_sample(MOST_POS, 1'b1);
        push_sample(5, 1'b0);                   // repeats in mixed order
        push_sample(5, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(5, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(MOST_POS, 1'b0);
        push_sample(MOST_POS, 1'b1);
        push_sample(-100, 1'b0);                // already ascending
        push_sample(-50, 1'b0);
        push_sample(0, 1'b0);
        push_sample(50, 1'b0);
        push_sample(100, 1'b1);
        push_sample(3, 1'b0);                   // descending
        push_sample(2, 1'b0);
        push_sample(1, 1'b0);
        push_sample(0, 1'b1);
        push_short_batches(20);
        hold_asks = hold_asks + 1;
        wait_drained();

        // sender slow, receiver quick; one batch fills the row exactly
        @(negedge i_clk);
        send_idle_pct = 74;
        recv_idle_pct = 30;
        push_batch(isort_pkg::CAPACITY);
        push_short_batches(10);
        wait_drained();

        // no idling; one batch overruns the row, its end item lost too
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_batch(isort_pkg::CAPACITY + 4);
        push_short_batches(10);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("insertion_sorter_core_tb OK");
        else
            $display("insertion_sorter_core_tb NOT OK");
        $finish;
    end

endmodule
